/* hdl/kmd_pkg.sv */
`default_nettype none

package kmd_pkg;

    // Number of keys scanned; pins at or above this index read as released
    localparam int KEY_COUNT = 8;
    localparam int SCAN_W    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PIN_W     = 8;

    localparam logic [PIN_W-1:0] USED_MASK = PIN_W'((1 << KEY_COUNT) - 1);

    // Number of vote samples in one window
    localparam int VOTE_N = 3;

    // Register map indexes
    localparam logic REG_SETTLE_WAIT    = 1'b0;
    localparam logic REG_SAMPLE_SPACING = 1'b1;

    localparam logic [15:0] SETTLE_WAIT_RST    = 16'd1000;
    localparam logic [7:0]  SAMPLE_SPACING_RST = 8'd10;

    // Pending event codes per key
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_PRESS   = 2'd1;
    localparam logic [1:0] PEND_RELEASE = 2'd2;

    // Packet constants
    localparam logic [3:0] CIN_NOTE_ON    = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF   = 4'h8;
    localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [6:0] VEL_ON         = 7'h7F;
    localparam logic [6:0] VEL_OFF        = 7'h00;

    typedef struct packed {
        logic [15:0] settle_wait;
        logic [7:0]  sample_spacing;
    } kmd_cfg_t;

    typedef struct packed {
        logic [6:0] velocity;
        logic [6:0] note_number;
        logic [7:0] status_byte;
        logic [3:0] code_index;
    } kmd_note_t;

    // Fixed note code of each key
    function automatic logic [6:0] note_of_key(input logic [SCAN_W-1:0] key);
        logic [6:0] n;
        unique case (3'(key))
            3'd0:    n = 7'h3C;
            3'd1:    n = 7'h3E;
            3'd2:    n = 7'h40;
            3'd3:    n = 7'h41;
            3'd4:    n = 7'h43;
            3'd5:    n = 7'h45;
            3'd6:    n = 7'h47;
            3'd7:    n = 7'h48;
            default: n = 7'h3C;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/key_majority_debounce_note_events.sv */
// Key debouncer with three-sample unanimous vote, reporting note packets.
//
// Input stream: one beat per tick. s_tdata[7:0] carries the raw active-low
// key pins, s_tuser[0] the host-ready flag. Output stream: at most one note
// beat per input beat; a beat whose scan index finds no pending key gives none.
// Configuration: APB port, settle_wait at 0x0, sample_spacing at 0x4; the user
// must write it only while the stream is idle, which the block does not enforce.
//
// Throughput: one input beat per cycle, sustained while the output is not stalled.
// A beat accepted lands in the input register, is processed into the result
// register, and its note appears on m_tvalid from there.
// The per-tick work is one pass of counter compares and bitwise logic
// between the input register and the output register.
//
// Stall: while m_tready is low and a note beat is waiting, the input
// register holds one more beat, then s_tready drops until the output drains.
// Reset (aresetn low, synchronous): counters and scan index clear, vote
// samples and the stable pattern read all released, no key is pending,
// settle_wait returns to 1000 and sample_spacing to 10.
`default_nettype none

module key_majority_debounce_note_events
    import kmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_pins
    input  wire logic [0:0]  s_tuser,   // [0] host_ready

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [3:0] code_index, [11:4] status_byte,
                                        // [18:12] note_number, [25:19] velocity

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    kmd_cfg_t   cfg;
    kmd_note_t  res;
    logic       item_taken;

    logic             in_valid_reg;
    logic [PIN_W-1:0] in_pins_reg;
    logic             in_ready_reg;

    kmd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: takes a beat when empty or when its content moves on
    assign s_tready = ~in_valid_reg | item_taken;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pins_reg  <= s_tdata[PIN_W-1:0];
            in_ready_reg <= s_tuser[0];
        end
    end

    kmd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (in_valid_reg),
        .key_pins   (in_pins_reg),
        .host_ready (in_ready_reg),
        .item_taken (item_taken),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {6'd0, res.velocity, res.note_number, res.status_byte, res.code_index};

endmodule

`default_nettype wire

/* hdl/kmd_cfg.sv */
`default_nettype none

module kmd_cfg
    import kmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output kmd_cfg_t         cfg
);

    logic [15:0] settle_wait_reg;
    logic [7:0]  sample_spacing_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_wait_reg    <= SETTLE_WAIT_RST;
            sample_spacing_reg <= SAMPLE_SPACING_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SETTLE_WAIT:    settle_wait_reg    <= pwdata[15:0];
                REG_SAMPLE_SPACING: sample_spacing_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_SETTLE_WAIT:    prdata = {16'd0, settle_wait_reg};
            REG_SAMPLE_SPACING: prdata = {24'd0, sample_spacing_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.settle_wait    = settle_wait_reg;
    assign cfg.sample_spacing = sample_spacing_reg;

endmodule

`default_nettype wire

/* hdl/kmd_core.sv */
`default_nettype none

module kmd_core
    import kmd_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire kmd_cfg_t         cfg,
    input  wire logic             item_valid,
    input  wire logic [PIN_W-1:0] key_pins,
    input  wire logic             host_ready,
    output logic                  item_taken,
    output logic                  res_valid,
    output kmd_note_t             res,
    input  wire logic             res_ready
);

    // Debounce state
    logic [15:0]       wait_reg,     wait_next;
    logic [7:0]        spacing_reg,  spacing_next;
    logic [1:0]        taken_reg,    taken_next;
    logic [PIN_W-1:0]  vs_reg   [VOTE_N];
    logic [PIN_W-1:0]  vs_next  [VOTE_N];
    logic [PIN_W-1:0]  stable_reg,   stable_next;
    logic [1:0]        pend_reg [KEY_COUNT];
    logic [1:0]        pend_next[KEY_COUNT];
    logic [SCAN_W-1:0] scan_reg,     scan_next;

    // Result register
    logic              res_valid_reg, res_valid_next;
    kmd_note_t         res_reg,       res_next;

    logic [PIN_W-1:0]  pins;
    logic              samp_en;
    logic [1:0]        taken_a;
    logic              vote_tick;
    logic              do_vote;
    logic [PIN_W-1:0]  changed;
    logic [SCAN_W-1:0] scan_a;
    logic [1:0]        pend_sel;
    logic              emit;
    logic              emit_on;

    // An item is processed when the result register is free or drains now
    assign item_taken = item_valid & (~res_valid_reg | res_ready);

    assign pins = key_pins | ~USED_MASK;

    // One tick of debounce, vote and scan
    always_comb begin
        samp_en = (wait_reg >= cfg.settle_wait) && (spacing_reg == 8'd0)
                  && (taken_reg < 2'(VOTE_N));
        taken_a = samp_en ? taken_reg + 2'd1 : taken_reg;
        for (int i = 0; i < VOTE_N; i++) begin
            vs_next[i] = (samp_en && (taken_reg == 2'(i))) ? pins : vs_reg[i];
        end
        vote_tick = (taken_a == 2'(VOTE_N));

        do_vote = host_ready && vote_tick
                  && (vs_next[0] == vs_next[1]) && (vs_next[1] == vs_next[2])
                  && (vs_next[0] != stable_reg);
        changed = vs_next[0] ^ stable_reg;

        for (int k = 0; k < KEY_COUNT; k++) begin
            pend_next[k] = pend_reg[k];
            if (do_vote && changed[k]) begin
                pend_next[k] = stable_reg[k] ? PEND_PRESS : PEND_RELEASE;
            end
        end
        stable_next = do_vote ? vs_next[1] : stable_reg;
        scan_a      = do_vote ? '0 : scan_reg;

        // Emit the key under the scan index
        pend_sel = pend_next[scan_a];
        emit     = (pend_sel == PEND_PRESS) || (pend_sel == PEND_RELEASE);
        emit_on  = (pend_sel == PEND_PRESS);
        if (emit) begin
            pend_next[scan_a] = PEND_NONE;
        end

        scan_next = (scan_a == SCAN_W'(KEY_COUNT - 1)) ? '0 : scan_a + SCAN_W'(1);

        // Settle wait and window restart
        wait_next  = wait_reg;
        taken_next = taken_a;
        if (wait_reg < cfg.settle_wait) begin
            wait_next = wait_reg + 16'd1;
        end else if (taken_a == 2'(VOTE_N)) begin
            wait_next  = 16'd0;
            taken_next = 2'd0;
        end

        // Spacing between samples
        if ((wait_next >= cfg.settle_wait) && (spacing_reg < cfg.sample_spacing)) begin
            spacing_next = spacing_reg + 8'd1;
        end else begin
            spacing_next = 8'd0;
        end
    end

    // Result register update
    always_comb begin
        res_valid_next = res_valid_reg & ~res_ready;
        res_next       = res_reg;
        if (item_taken) begin
            res_valid_next       = emit;
            res_next.code_index  = emit_on ? CIN_NOTE_ON    : CIN_NOTE_OFF;
            res_next.status_byte = emit_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF;
            res_next.note_number = note_of_key(scan_a);
            res_next.velocity    = emit_on ? VEL_ON         : VEL_OFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg      <= 16'd0;
            spacing_reg   <= 8'd0;
            taken_reg     <= 2'd0;
            stable_reg    <= '1;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < VOTE_N; i++) begin
                vs_reg[i] <= '1;
            end
            for (int k = 0; k < KEY_COUNT; k++) begin
                pend_reg[k] <= PEND_NONE;
            end
        end else begin
            res_valid_reg <= res_valid_next;
            if (item_taken) begin
                wait_reg    <= wait_next;
                spacing_reg <= spacing_next;
                taken_reg   <= taken_next;
                stable_reg  <= stable_next;
                scan_reg    <= scan_next;
                for (int i = 0; i < VOTE_N; i++) begin
                    vs_reg[i] <= vs_next[i];
                end
                for (int k = 0; k < KEY_COUNT; k++) begin
                    pend_reg[k] <= pend_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
